/* hw/rtl/assert_macros.svh */
// Assertion helpers for the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every rising clock edge outside reset.
`define CHECK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition at one edge implies a consequence at the same edge.
`define CHECK_IMPLIES(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mkd_pkg.sv */
`timescale 1ns / 1ps

package mkd_pkg;

    localparam int unsigned MAX_SYMBOLS_DEF = 16;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam int unsigned CODE_W  = 6;
    localparam int unsigned LENC_W  = 3;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned KIND_W  = 3;

    localparam logic [TICK_W-1:0] DASH_TICKS_RST = 16'h4000;
    localparam logic [TICK_W-1:0] GAP_TICKS_RST  = 16'h8000;
    localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;

    localparam logic CFG_IDX_DASH = 1'b0;
    localparam logic CFG_IDX_GAP  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_LETTER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPACE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DOT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DASH    = 3'd4;

    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_UNDER = 7'h5F;

    // Length class for a decode: the real length up to six, otherwise too long.
    localparam logic [LENC_W-1:0] LEN_TOO_LONG = 3'd7;

    typedef enum logic [1:0] {
        EV_DOT,
        EV_DASH,
        EV_SPACE,
        EV_DECODE
    } t_ev_op;

    typedef struct packed {
        t_ev_op              op;
        logic [CODE_W-1:0]   bits;
        logic [LENC_W-1:0]   len;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_q_push;

    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_q_head;

    // Returns {found, character}; the first symbol sits in the highest used bit, 1 is a dash.
    function automatic logic [CHAR_W:0] morse_lookup(input logic [LENC_W-1:0] len,
                                                     input logic [CODE_W-1:0] bits);
        logic [CHAR_W:0] res;
        res = '0;
        unique case (len)
            3'd1: begin
                unique case (bits[0])
                    1'b0: res = {1'b1, 7'h45};
                    1'b1: res = {1'b1, 7'h54};
                    default: res = '0;
                endcase
            end
            3'd2: begin
                unique case (bits[1:0])
                    2'b00: res = {1'b1, 7'h49};
                    2'b01: res = {1'b1, 7'h41};
                    2'b10: res = {1'b1, 7'h4E};
                    2'b11: res = {1'b1, 7'h4D};
                    default: res = '0;
                endcase
            end
            3'd3: begin
                unique case (bits[2:0])
                    3'b000: res = {1'b1, 7'h53};
                    3'b001: res = {1'b1, 7'h55};
                    3'b010: res = {1'b1, 7'h52};
                    3'b011: res = {1'b1, 7'h57};
                    3'b100: res = {1'b1, 7'h44};
                    3'b101: res = {1'b1, 7'h4B};
                    3'b110: res = {1'b1, 7'h47};
                    3'b111: res = {1'b1, 7'h4F};
                    default: res = '0;
                endcase
            end
            3'd4: begin
                unique case (bits[3:0])
                    4'b0000: res = {1'b1, 7'h48};
                    4'b0001: res = {1'b1, 7'h56};
                    4'b0010: res = {1'b1, 7'h46};
                    4'b0100: res = {1'b1, 7'h4C};
                    4'b0110: res = {1'b1, 7'h50};
                    4'b0111: res = {1'b1, 7'h4A};
                    4'b1000: res = {1'b1, 7'h42};
                    4'b1001: res = {1'b1, 7'h58};
                    4'b1010: res = {1'b1, 7'h43};
                    4'b1011: res = {1'b1, 7'h59};
                    4'b1100: res = {1'b1, 7'h5A};
                    4'b1101: res = {1'b1, 7'h51};
                    default: res = '0;
                endcase
            end
            3'd5: begin
                unique case (bits[4:0])
                    5'b11111: res = {1'b1, 7'h30};
                    5'b01111: res = {1'b1, 7'h31};
                    5'b00111: res = {1'b1, 7'h32};
                    5'b00011: res = {1'b1, 7'h33};
                    5'b00001: res = {1'b1, 7'h34};
                    5'b00000: res = {1'b1, 7'h35};
                    5'b10000: res = {1'b1, 7'h36};
                    5'b11000: res = {1'b1, 7'h37};
                    5'b11100: res = {1'b1, 7'h38};
                    5'b11110: res = {1'b1, 7'h39};
                    default: res = '0;
                endcase
            end
            3'd6: begin
                unique case (bits)
                    6'b110011: res = {1'b1, 7'h2C};
                    6'b010101: res = {1'b1, 7'h2E};
                    6'b001100: res = {1'b1, 7'h3F};
                    6'b101011: res = {1'b1, 7'h21};
                    default: res = '0;
                endcase
            end
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

/* hw/rtl/mkd_front.sv */
`timescale 1ns / 1ps

module mkd_front
    import mkd_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_key_down,
    input  logic              i_discard,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic              i_q_full,
    output t_q_push           o_push
);

    localparam int unsigned LEN_W = $clog2(MAX_SYMBOLS + 1);

    logic [TICK_W-1:0] r_dash_ticks, n_dash_ticks;
    logic [TICK_W-1:0] r_gap_ticks, n_gap_ticks;
    logic              r_key_was_down, n_key_was_down;
    logic              r_still_dot, n_still_dot;
    logic              r_letter, n_letter;
    logic              r_space, n_space;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic              r_running, n_running;
    logic [CODE_W-1:0] r_bits, n_bits;
    logic [LEN_W-1:0]  r_len, n_len;

    logic              w_accept;
    logic [TICK_W-1:0] w_tick_inc;
    logic [TICK_W-1:0] w_period;
    logic [LENC_W-1:0] w_len_class;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dash_ticks   <= DASH_TICKS_RST;
            r_gap_ticks    <= GAP_TICKS_RST;
            r_key_was_down <= 1'b0;
            r_still_dot    <= 1'b1;
            r_letter       <= 1'b0;
            r_space        <= 1'b0;
            r_tick         <= '0;
            r_running      <= 1'b0;
            r_bits         <= '0;
            r_len          <= '0;
        end else begin
            r_dash_ticks   <= n_dash_ticks;
            r_gap_ticks    <= n_gap_ticks;
            r_key_was_down <= n_key_was_down;
            r_still_dot    <= n_still_dot;
            r_letter       <= n_letter;
            r_space        <= n_space;
            r_tick         <= n_tick;
            r_running      <= n_running;
            r_bits         <= n_bits;
            r_len          <= n_len;
        end
    end

    always_comb begin
        n_dash_ticks = r_dash_ticks;
        n_gap_ticks  = r_gap_ticks;
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_DASH) begin
                n_dash_ticks = i_cfg_data;
            end else begin
                n_gap_ticks = i_cfg_data;
            end
        end
    end

    always_comb begin
        w_tick_inc  = (r_tick < TICK_MAX) ? r_tick + 1'b1 : r_tick;
        w_period    = r_key_was_down ? r_dash_ticks : r_gap_ticks;
        w_len_class = (r_len > LEN_W'(6)) ? LEN_TOO_LONG : LENC_W'(r_len);

        n_key_was_down = r_key_was_down;
        n_still_dot    = r_still_dot;
        n_letter       = r_letter;
        n_space        = r_space;
        n_tick         = r_tick;
        n_running      = r_running;
        n_bits         = r_bits;
        n_len          = r_len;

        o_push.valid   = 1'b0;
        o_push.ev.op   = EV_DOT;
        o_push.ev.bits = r_bits;
        o_push.ev.len  = w_len_class;

        if (w_accept) begin
            priority if (i_discard) begin
                n_running      = 1'b0;
                n_tick         = '0;
                n_bits         = '0;
                n_len          = '0;
                n_still_dot    = 1'b1;
                n_letter       = 1'b0;
                n_space        = 1'b0;
                n_key_was_down = 1'b0;
            end else if (i_key_down != r_key_was_down) begin
                if (!i_key_down && (r_len < LEN_W'(MAX_SYMBOLS))) begin
                    if (r_len < LEN_W'(CODE_W)) begin
                        n_bits = {r_bits[CODE_W-2:0], !r_still_dot};
                    end
                    n_len        = r_len + 1'b1;
                    o_push.valid = 1'b1;
                    o_push.ev.op = r_still_dot ? EV_DOT : EV_DASH;
                end
                n_still_dot    = 1'b1;
                n_letter       = 1'b0;
                n_space        = 1'b0;
                n_tick         = '0;
                n_running      = 1'b1;
                n_key_was_down = i_key_down;
            end else if (r_running) begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= w_period) begin
                    n_running   = 1'b0;
                    n_tick      = '0;
                    n_still_dot = 1'b0;
                    if (!r_key_was_down) begin
                        n_letter = 1'b1;
                        if (r_letter) begin
                            n_space      = 1'b1;
                            o_push.valid = 1'b1;
                            o_push.ev.op = EV_SPACE;
                        end else if (!r_space) begin
                            o_push.valid = 1'b1;
                            o_push.ev.op = EV_DECODE;
                            n_bits       = '0;
                            n_len        = '0;
                            n_running    = 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

/* hw/rtl/mkd_queue.sv */
`timescale 1ns / 1ps

module mkd_queue
    import mkd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.ev    = r_mem[r_rptr];

    always_comb begin
        w_do_push = i_push.valid && !o_full;
        w_do_pop  = i_pop && o_head.valid;
        n_wptr    = r_wptr;
        n_rptr    = r_rptr;
        n_count   = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_push.ev;
        end
    end

endmodule

/* hw/rtl/mkd_back.sv */
`timescale 1ns / 1ps

module mkd_back
    import mkd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_head           i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char_code,
    output logic [KIND_W-1:0] o_kind
);

    logic              r_valid, n_valid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [CHAR_W:0]   w_lookup;

    assign o_pop       = i_head.valid && (!r_valid || i_ready);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_kind      = r_kind;

    always_comb begin
        w_lookup = morse_lookup(i_head.ev.len, i_head.ev.bits);
        n_valid  = r_valid && !i_ready;
        n_char   = r_char;
        n_kind   = r_kind;
        if (o_pop) begin
            n_valid = 1'b1;
            unique case (i_head.ev.op)
                EV_DOT: begin
                    n_char = CH_DOT;
                    n_kind = KIND_DOT;
                end
                EV_DASH: begin
                    n_char = CH_UNDER;
                    n_kind = KIND_DASH;
                end
                EV_SPACE: begin
                    n_char = CH_UNDER;
                    n_kind = KIND_SPACE;
                end
                EV_DECODE: begin
                    n_char = w_lookup[CHAR_W] ? w_lookup[CHAR_W-1:0] : CH_MINUS;
                    n_kind = w_lookup[CHAR_W] ? KIND_LETTER : KIND_UNKNOWN;
                end
                default: begin
                    n_char = CH_MINUS;
                    n_kind = KIND_UNKNOWN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_kind <= n_kind;
    end

endmodule

/* hw/rtl/morse_key_decoder_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// s_axis    in         i_s_axis_tvalid/o_tready  tdata[0] key_down, tdata[1] discard
// m_axis    out        o_m_axis_tvalid/i_tready  tdata[6:0] char_code, tuser[2:0] kind
// cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data[15:0]
//
// One item is taken each cycle the queue is not full; timer and symbols update in that cycle.
// An item's result is written into the event queue and then into the output register.
// The two-entry event queue sets when the input stalls: it fills only while the output is held.
// Reset is synchronous and active low; it clears timers, symbols, queue and output valid.
// Configuration writes are always taken.

module morse_key_decoder_unit
    import mkd_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [0] key_down, [1] discard, [7:2] zero
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic [KIND_W-1:0] o_m_axis_tuser,   // [2:0] kind
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [TICK_W-1:0] i_cfg_data
);

    t_q_push           w_push;
    t_q_head           w_head;
    logic              w_q_full;
    logic              w_pop;
    logic [CHAR_W-1:0] w_char;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {1'b0, w_char};

    mkd_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_key_down  (i_s_axis_tdata[0]),
        .i_discard   (i_s_axis_tdata[1]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_push      (w_push)
    );

    mkd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    mkd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char_code (w_char),
        .o_kind      (o_m_axis_tuser)
    );

`include "assert_macros.svh"

    `CHECK_IMPLIES(a_push_not_full, i_clk, i_rst_n, w_push.valid, !w_q_full, "event pushed into a full queue")
    `CHECK_IMPLIES(a_pop_has_room, i_clk, i_rst_n, w_pop, !o_m_axis_tvalid || i_m_axis_tready, "queue popped while the output item is held")
    `CHECK_ALWAYS(a_kind_range, i_clk, i_rst_n, !o_m_axis_tvalid || (o_m_axis_tuser <= KIND_DASH), "output kind out of range")

endmodule
